### sv/bmf_pkg.sv
// shared constants and the cell record of the block median filter
package bmf_pkg;

    localparam int SAMPLE_W   = 14;
    localparam int MAX_WIN    = 32;
    localparam int TAG_W      = $clog2(MAX_WIN);
    localparam int SIZE_W     = 6;
    localparam int TDATA_W    = ((SAMPLE_W + 7) / 8) * 8;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(5);

    // one slot of the sorted chain: arrival order tag and sample value
    typedef struct packed {
        logic                vld;
        logic [TAG_W-1:0]    tag;
        logic [SAMPLE_W-1:0] val;
    } t_cell;

endpackage

### sv/bmf_cell.sv
// one slot of the sorted insertion chain
module bmf_cell (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_ins,
    input  logic                           i_shift,
    input  logic                           i_clr,
    input  logic [bmf_pkg::SAMPLE_W-1:0]   i_sample,
    input  logic [bmf_pkg::TAG_W-1:0]      i_tag,
    input  bmf_pkg::t_cell                 i_left,
    input  logic                           i_left_gt,
    input  bmf_pkg::t_cell                 i_right,
    output bmf_pkg::t_cell                 o_cell,
    output logic                           o_gt
);
    import bmf_pkg::*;

    t_cell r_cell;
    t_cell n_cell;

    // an empty slot counts as larger than any sample
    assign o_gt   = !r_cell.vld || (r_cell.val > i_sample);
    assign o_cell = r_cell;

    always_comb begin
        n_cell = r_cell;
        if (i_clr) begin
            n_cell.vld = 1'b0;
        end else if (i_shift) begin
            n_cell = i_right;
        end else if (i_ins && o_gt) begin
            if (i_left_gt) begin
                n_cell = i_left;
            end else begin
                n_cell.vld = 1'b1;
                n_cell.tag = i_tag;
                n_cell.val = i_sample;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.vld <= 1'b0;
        end else begin
            r_cell <= n_cell;
        end
    end

endmodule

### sv/block_median_filter.sv
// block median filter: sorted insertion chain with windowed median pick
// throughput: one sample per cycle while a window fills; after the last sample of a
//   window s_axis_tready stays low through pick, then output load
// the median goes to r_res at pick and onto m_axis_tdata at load, which waits for a free output
// a window shortened mid-fill walks the chain from its low end
// reset: window size 5, fill count zero, chain empty, no result pending
module block_median_filter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [bmf_pkg::SIZE_W-1:0]    i_cfg_wdata,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [bmf_pkg::TDATA_W-1:0]   s_axis_tdata,   // [13:0] sample
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [bmf_pkg::TDATA_W-1:0]   m_axis_tdata    // [13:0] median
);
    import bmf_pkg::*;

    localparam logic [1:0] ST_RUN  = 2'd0;
    localparam logic [1:0] ST_PICK = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_LOAD = 2'd3;

    logic [1:0]          r_state, n_state;
    logic [SIZE_W-1:0]   r_size;
    logic [SIZE_W-1:0]   r_fill, n_fill;
    logic [TAG_W-1:0]    r_skip, n_skip;
    logic [SAMPLE_W-1:0] r_res, n_res;
    logic                r_ovld, n_ovld;
    logic [SAMPLE_W-1:0] r_med, n_med;

    logic [SIZE_W-1:0]   w_size;
    logic                w_accept;
    logic                w_ins, w_shift, w_clr;
    logic                w_out_free;
    t_cell               w_cell [MAX_WIN];
    logic                w_gt   [MAX_WIN];
    logic [MAX_WIN-1:0]  w_vld;

    // zero acts as one, anything above capacity saturates
    always_comb begin
        if (r_size == '0) begin
            w_size = SIZE_W'(1);
        end else if (r_size > SIZE_W'(MAX_WIN)) begin
            w_size = SIZE_W'(MAX_WIN);
        end else begin
            w_size = r_size;
        end
    end

    assign s_axis_tready = (r_state == ST_RUN);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_ovld || m_axis_tready;
    assign w_ins         = w_accept;
    assign w_shift       = (r_state == ST_SCAN);
    assign w_clr         = (r_state == ST_LOAD) && w_out_free;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_WIN; gi++) begin : g_chain
            t_cell w_left, w_right;
            logic  w_left_gt;
            if (gi == 0) begin : g_first
                assign w_left    = '0;
                assign w_left_gt = 1'b0;
            end else begin : g_mid
                assign w_left    = w_cell[gi-1];
                assign w_left_gt = w_gt[gi-1];
            end
            if (gi == MAX_WIN - 1) begin : g_last
                assign w_right = '0;
            end else begin : g_inner
                assign w_right = w_cell[gi+1];
            end
            assign w_vld[gi] = w_cell[gi].vld;

            bmf_cell u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_ins     (w_ins),
                .i_shift   (w_shift),
                .i_clr     (w_clr),
                .i_sample  (s_axis_tdata[SAMPLE_W-1:0]),
                .i_tag     (r_fill[TAG_W-1:0]),
                .i_left    (w_left),
                .i_left_gt (w_left_gt),
                .i_right   (w_right),
                .o_cell    (w_cell[gi]),
                .o_gt      (w_gt[gi])
            );
        end
    endgenerate

    always_comb begin
        n_state = r_state;
        n_fill  = r_fill;
        n_skip  = r_skip;
        n_res   = r_res;
        n_ovld  = r_ovld;
        n_med   = r_med;

        if (r_ovld && m_axis_tready) begin
            n_ovld = 1'b0;
        end

        unique case (r_state)
            ST_RUN: begin
                if (w_accept) begin
                    n_fill = r_fill + SIZE_W'(1);
                    n_skip = w_size[SIZE_W-1:1];
                    if (r_fill >= w_size) begin
                        // window was shortened: keep only the earliest entries
                        n_state = ST_SCAN;
                    end else if (r_fill + SIZE_W'(1) == w_size) begin
                        n_state = ST_PICK;
                    end
                end
            end
            ST_PICK: begin
                n_res   = w_cell[w_size[SIZE_W-1:1]].val;
                n_state = ST_LOAD;
            end
            ST_SCAN: begin
                if (w_cell[0].vld && ({1'b0, w_cell[0].tag} < w_size)) begin
                    if (r_skip == '0) begin
                        n_res   = w_cell[0].val;
                        n_state = ST_LOAD;
                    end else begin
                        n_skip = r_skip - TAG_W'(1);
                    end
                end
            end
            ST_LOAD: begin
                if (w_out_free) begin
                    n_med   = r_res;
                    n_ovld  = 1'b1;
                    n_fill  = '0;
                    n_state = ST_RUN;
                end
            end
            default: n_state = ST_RUN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RUN;
            r_size  <= SIZE_RESET;
            r_fill  <= '0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_ovld  <= n_ovld;
            if (i_cfg_we) begin
                r_size <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_skip <= n_skip;
        r_res  <= n_res;
        r_med  <= n_med;
    end

    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = {{(TDATA_W - SAMPLE_W){1'b0}}, r_med};

    // chain occupancy follows the fill count while samples are taken
    a_fill_matches_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> ($countones(w_vld) == int'(r_fill)))
        else $error("chain occupancy differs from fill count");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> (r_fill < SIZE_W'(MAX_WIN)))
        else $error("fill count reached capacity without a result");

    a_pick_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PICK) |-> w_cell[w_size[SIZE_W-1:1]].vld)
        else $error("median slot empty at pick");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_LOAD) && w_out_free) |=> (m_axis_tvalid && (r_state == ST_RUN)))
        else $error("result not presented after load");

endmodule

### tb/bmf_median_check.sv
// checker for the block median filter: mirrors the sample window and checks each median beat
module bmf_median_check (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [bmf_pkg::SIZE_W-1:0]  i_cfg_wdata,
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  logic [bmf_pkg::TDATA_W-1:0] i_in_data,    // [13:0] sample
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic [bmf_pkg::TDATA_W-1:0] i_out_data,   // [13:0] median
    output int                          o_fail_count,
    output int                          o_pending
);
    import bmf_pkg::*;

    logic [SAMPLE_W-1:0] window_cells [MAX_WIN];
    int unsigned         cells_filled;
    logic [SIZE_W-1:0]   size_reg;
    logic [SAMPLE_W-1:0] medians_due [$];
    int                  fails = 0;

    assign o_fail_count = fails;

    // a zero size acts as one, anything past the store is clipped to it
    function automatic int unsigned window_span(input logic [SIZE_W-1:0] r);
        int unsigned n;
        n = 32'(r);
        if (n == 0) n = 1;
        if (n > MAX_WIN) n = MAX_WIN;
        return n;
    endfunction

    function automatic logic [SAMPLE_W-1:0] middle_of_window(input int unsigned n);
        logic [SAMPLE_W-1:0] row [MAX_WIN];
        logic [SAMPLE_W-1:0] v;
        int                  j;
        for (int i = 0; i < n; i++) row[i] = window_cells[i];
        for (int i = 1; i < n; i++) begin
            v = row[i];
            j = i;
            while (j > 0 && row[j-1] > v) begin
                row[j] = row[j-1];
                j--;
            end
            row[j] = v;
        end
        return row[n/2];
    endfunction

    always @(posedge i_clk) begin
        int unsigned         slot;
        int unsigned         span;
        logic [SAMPLE_W-1:0] got;
        if (!i_rst_n) begin
            cells_filled = 0;
            size_reg     = SIZE_RESET;
            medians_due.delete();
        end else begin
            // no median can leave on the beat of its own last sample
            if (i_out_valid && i_out_ready) begin
                got = i_out_data[SAMPLE_W-1:0];
                if (medians_due.size() == 0) begin
                    $error("median beat %0d with no completed window", got);
                    fails++;
                end else begin
                    if (got !== medians_due[0]) begin
                        $error("median mismatch: expected %0d, actual %0d",
                               medians_due[0], got);
                        fails++;
                    end
                    void'(medians_due.pop_front());
                end
            end
            if (i_cfg_we) size_reg = i_cfg_wdata;
            if (i_in_valid && i_in_ready) begin
                span = window_span(size_reg);
                slot = (cells_filled >= MAX_WIN) ? MAX_WIN - 1 : cells_filled;
                window_cells[slot] = i_in_data[SAMPLE_W-1:0];
                cells_filled = slot + 1;
                // a shortened window closes on the first sample that reaches it
                if (cells_filled >= span) begin
                    medians_due.push_back(middle_of_window(span));
                    cells_filled = 0;
                end
            end
        end
        o_pending <= medians_due.size();
    end

endmodule

### tb/testbench.sv
// stimulus and verdict for the block median filter regression
module testbench;
    import bmf_pkg::*;

    localparam int RANDOM_ITEMS = 450;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int SETTLE       = 40;
    localparam int LONG_HOLD    = 400;

    typedef enum {SPREAD_FULL, SPREAD_CLUSTER, SPREAD_EDGE} t_spread;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [SIZE_W-1:0]  i_cfg_wdata;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [TDATA_W-1:0] s_axis_tdata;
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [TDATA_W-1:0] m_axis_tdata;

    int fail_count;
    int pending;
    int cycles = 0;
    bit hold_wanted = 1'b0;
    bit hold_served = 1'b0;

    block_median_filter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    bmf_median_check check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(12, 45);
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample(input t_spread spread,
                                                         input logic [SAMPLE_W-1:0] anchor);
        logic [SAMPLE_W-1:0] bitpos;
        case (spread)
            SPREAD_CLUSTER: begin
                // narrow spread around one value, plenty of ties
                return anchor ^ SAMPLE_W'($urandom_range(0, 7));
            end
            SPREAD_EDGE: begin
                bitpos = SAMPLE_W'(1) << $urandom_range(0, SAMPLE_W - 1);
                case ($urandom_range(0, 3))
                    0:       return '0;
                    1:       return '1;
                    2:       return bitpos;
                    default: return ~bitpos;
                endcase
            end
            default: return SAMPLE_W'($urandom_range(0, 16383));
        endcase
    endfunction

    // called at a falling edge, returns at the falling edge after the beat
    task automatic send_sample(input logic [SAMPLE_W-1:0] value, input bit steady);
        int unsigned gap;
        gap = steady ? 0 : idle_len();
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= TDATA_W'(value);
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // size changes only with the block drained and the chain walk given time
    task automatic write_size(input logic [SIZE_W-1:0] value);
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // result side: random back-pressure, steady stretches and one long hold-off
    initial begin
        bit rx_steady;
        int unsigned gap;
        rx_steady = 1'b0;
        m_axis_tready = 1'b0;
        @(negedge i_clk);
        forever begin
            if ($urandom_range(0, 63) == 0) rx_steady = ~rx_steady;
            if (hold_wanted && !hold_served) begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
                hold_served = 1'b1;
            end else begin
                gap = rx_steady ? 0 : idle_len();
                if (gap == 0) begin
                    m_axis_tready <= 1'b1;
                    @(negedge i_clk);
                end else begin
                    m_axis_tready <= 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
            end
        end
    end

    initial begin
        int                  sent;
        int                  phase;
        int unsigned         span;
        int unsigned         count;
        logic [SIZE_W-1:0]   size_val;
        logic [SAMPLE_W-1:0] anchor;
        t_spread             spread;
        bit                  steady;

        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset size of five with the field extremes
        send_sample(14'd16383, 1'b0);
        send_sample(14'd0, 1'b0);
        send_sample(14'd8191, 1'b0);
        send_sample(14'd8192, 1'b0);
        send_sample(14'd16383, 1'b0);

        // zero size passes every sample straight through
        write_size(6'd0);
        send_sample(14'h2AAA, 1'b0);
        send_sample(14'h1555, 1'b0);

        // even window picks the upper middle
        write_size(6'd4);
        send_sample(14'd3, 1'b0);
        send_sample(14'd1, 1'b0);
        send_sample(14'd4, 1'b0);
        send_sample(14'd2, 1'b0);

        // window cut short after four samples: the next one closes it on the first two
        write_size(6'd6);
        send_sample(14'd100, 1'b0);
        send_sample(14'd50, 1'b0);
        send_sample(14'd75, 1'b0);
        send_sample(14'd25, 1'b0);
        write_size(6'd2);
        send_sample(14'd10, 1'b1);

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: size_val = SIZE_W'($urandom_range(1, 8));
                11, 12, 13: size_val = SIZE_W'($urandom_range(9, 31));
                14:         size_val = 6'd32;
                15:         size_val = SIZE_W'($urandom_range(33, 63));
                16:         size_val = 6'd0;
                default:    size_val = SIZE_W'($urandom_range(2, 5));
            endcase
            if (phase == 0) size_val = 6'd63;
            if (phase == 1) size_val = 6'd32;
            if (phase == 2) size_val = 6'd3;
            if (phase == 3) size_val = 6'd1;
            write_size(size_val);

            span = (size_val == 0) ? 1 : (size_val > MAX_WIN) ? MAX_WIN : size_val;
            count = span * ((span <= 8) ? $urandom_range(1, 4) : $urandom_range(1, 2));
            // leave some windows partly full so the next setting cuts into them
            if (span > 1 && $urandom_range(0, 2) == 0) count += $urandom_range(1, span - 1);
            steady = ($urandom_range(0, 3) == 0);
            spread = t_spread'($urandom_range(0, 2));
            anchor = SAMPLE_W'($urandom_range(0, 16383));
            if (phase == 2) begin
                count       = 45;
                steady      = 1'b1;
                hold_wanted = 1'b1;
            end
            repeat (count) send_sample(pick_sample(spread, anchor), steady);
            sent  += count;
            phase++;
        end

        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
